>>> rtl/rgbhsv_pkg.sv
// Shared types, constants and helpers for the RGB to HSV converter.
// No dependencies; used by rgbhsv_div_pipe and rgb_to_hsv_converter_top.
package rgbhsv_pkg;

   // Default component width
   localparam int COMPONENT_BITS_DEF = 8;

   // Hue format: whole degrees, 0 to 359
   localparam int HUE_BITS = 9;
   // Hue quotient 60*diff/delta never exceeds 60
   localparam int HUE_QUOT_BITS = 6;
   localparam int HUE_SCALE = 60;
   localparam int HUE_FULL_TURN = 360;

   // Sector chosen by the largest component, red first, then green, then blue
   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // Sideband carried alongside the hue division
   typedef struct packed {
      logic       grey;
      logic       neg;
      sector_type sector;
   } hue_side_type;

   // Hue offset of each sector in degrees
   function automatic logic [HUE_BITS-1:0] sector_offset(input sector_type sector);
      logic [HUE_BITS-1:0] offset;
      unique case (sector)
         SECTOR_RED:   offset = HUE_BITS'(0);
         SECTOR_GREEN: offset = HUE_BITS'(120);
         SECTOR_BLUE:  offset = HUE_BITS'(240);
         default:      offset = HUE_BITS'(0);
      endcase
      return offset;
   endfunction

endpackage

>>> rtl/rgbhsv_div_pipe.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Carries a valid bit and an opaque sideband word; depends on rgbhsv_pkg.
module rgbhsv_div_pipe
   import rgbhsv_pkg::*;
#(
   parameter int NUM_BITS  = 14,
   parameter int DEN_BITS  = 8,
   parameter int QUOT_BITS = 8,
   parameter int SIDE_BITS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [NUM_BITS-1:0]  in_num,
   input  logic [DEN_BITS-1:0]  in_den,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   output logic [QUOT_BITS-1:0] out_quot,
   output logic                 out_rem_nz,
   output logic [SIDE_BITS-1:0] out_side
);

   // Remainder is kept one bit wider than the largest shifted divisor
   localparam int EXT_BITS = DEN_BITS + QUOT_BITS;

   logic                 valid_ff [QUOT_BITS];
   logic [EXT_BITS-1:0]  rem_ff   [QUOT_BITS];
   logic [DEN_BITS-1:0]  den_ff   [QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_ff  [QUOT_BITS];
   logic [SIDE_BITS-1:0] side_ff  [QUOT_BITS];

   logic [EXT_BITS-1:0]  rem_in   [QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_in  [QUOT_BITS];

   genvar s;
   generate
      for (s = 0; s < QUOT_BITS; s++) begin : g_stage
         localparam int SHIFT = QUOT_BITS - 1 - s;

         logic                 prev_valid;
         logic [EXT_BITS-1:0]  prev_rem;
         logic [DEN_BITS-1:0]  prev_den;
         logic [QUOT_BITS-1:0] prev_quot;
         logic [SIDE_BITS-1:0] prev_side;
         logic [EXT_BITS-1:0]  trial;
         logic                 fits;

         // Pick up the previous stage, or the inputs for the first one
         if (s == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_rem   = EXT_BITS'(in_num);
            assign prev_den   = in_den;
            assign prev_quot  = '0;
            assign prev_side  = in_side;
         end else begin : g_next
            assign prev_valid = valid_ff[s-1];
            assign prev_rem   = rem_ff[s-1];
            assign prev_den   = den_ff[s-1];
            assign prev_quot  = quot_ff[s-1];
            assign prev_side  = side_ff[s-1];
         end

         // Trial subtract of the divisor aligned to this quotient bit
         always_comb begin
            trial      = EXT_BITS'(prev_den) << SHIFT;
            fits       = (prev_rem >= trial);
            rem_in[s]  = fits ? (prev_rem - trial) : prev_rem;
            quot_in[s] = {prev_quot[QUOT_BITS-2:0], fits};
         end

         // Advance one stage
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else begin
               valid_ff[s] <= prev_valid;
            end
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= prev_den;
            quot_ff[s] <= quot_in[s];
            side_ff[s] <= prev_side;
         end
      end
   endgenerate

   assign out_valid  = valid_ff[QUOT_BITS-1];
   assign out_quot   = quot_ff[QUOT_BITS-1];
   assign out_rem_nz = (rem_ff[QUOT_BITS-1] != '0);
   assign out_side   = side_ff[QUOT_BITS-1];

endmodule

>>> rtl/rgb_to_hsv_converter_top.sv
// RGB to HSV converter: takes one pixel per clock, never busy.
// A result passes the pixel, max/min and numerator registers, both divider pipelines
// and the output register; DIV_STAGES = max(COMPONENT_BITS, 6).
// Throughput: one pixel per cycle, set by the one-bit-per-stage divider pipeline.
// Reset clears every valid bit; the receiver takes each result in its strobe cycle.
// Depends on rgbhsv_pkg and rgbhsv_div_pipe.
module rgb_to_hsv_converter_top
   import rgbhsv_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [COMPONENT_BITS-1:0] req_red,
   input  logic [COMPONENT_BITS-1:0] req_green,
   input  logic [COMPONENT_BITS-1:0] req_blue,
   output logic                      rsp_strobe,
   output logic [HUE_BITS-1:0]       rsp_hue_degrees,
   output logic [COMPONENT_BITS-1:0] rsp_saturation,
   output logic [COMPONENT_BITS-1:0] rsp_brightness
);

   localparam int N          = COMPONENT_BITS;
   localparam int DIV_STAGES = (N > HUE_QUOT_BITS) ? N : HUE_QUOT_BITS;
   localparam int HUE_NUM_BITS = N + HUE_QUOT_BITS;
   localparam int SAT_NUM_BITS = 2 * N;
   localparam logic [N-1:0] FULL_SCALE = {N{1'b1}};
   localparam int SIDE_BITS = $bits(hue_side_type);

   // Every cycle can take a pixel
   assign busy = 1'b0;

   // ---------------- Stage 1: register the pixel ----------------
   logic         s1_valid_ff;
   logic [N-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
      s1_red_ff   <= req_red;
      s1_green_ff <= req_green;
      s1_blue_ff  <= req_blue;
   end

   // ---------------- Stage 2: max, min, sector ----------------
   logic         s2_valid_ff;
   logic [N-1:0] s2_max_ff, s2_min_ff, s2_pa_ff, s2_pb_ff;
   sector_type   s2_sector_ff;

   logic [N-1:0] s2_max_in, s2_min_in, s2_pa_in, s2_pb_in;
   sector_type   s2_sector_in;

   // Choose the sector with red first, then green, then blue
   always_comb begin
      if (s1_red_ff >= s1_green_ff && s1_red_ff >= s1_blue_ff) begin
         s2_sector_in = SECTOR_RED;
         s2_max_in    = s1_red_ff;
         s2_pa_in     = s1_green_ff;
         s2_pb_in     = s1_blue_ff;
      end else if (s1_green_ff >= s1_blue_ff) begin
         s2_sector_in = SECTOR_GREEN;
         s2_max_in    = s1_green_ff;
         s2_pa_in     = s1_blue_ff;
         s2_pb_in     = s1_red_ff;
      end else begin
         s2_sector_in = SECTOR_BLUE;
         s2_max_in    = s1_blue_ff;
         s2_pa_in     = s1_red_ff;
         s2_pb_in     = s1_green_ff;
      end
      s2_min_in = s1_red_ff;
      if (s1_green_ff < s2_min_in) begin
         s2_min_in = s1_green_ff;
      end
      if (s1_blue_ff < s2_min_in) begin
         s2_min_in = s1_blue_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_max_ff    <= s2_max_in;
      s2_min_ff    <= s2_min_in;
      s2_pa_ff     <= s2_pa_in;
      s2_pb_ff     <= s2_pb_in;
      s2_sector_ff <= s2_sector_in;
   end

   // ---------------- Stage 3: delta and numerators ----------------
   logic                    s3_valid_ff;
   logic [HUE_NUM_BITS-1:0] s3_hue_num_ff;
   logic [SAT_NUM_BITS-1:0] s3_sat_num_ff;
   logic [N-1:0]            s3_delta_ff, s3_max_ff;
   hue_side_type            s3_side_ff;

   logic [N-1:0]            s3_delta_in, s3_mag_in;
   logic [HUE_NUM_BITS-1:0] s3_hue_num_in;
   logic [SAT_NUM_BITS-1:0] s3_sat_num_in;
   hue_side_type            s3_side_in;

   // Scale the sector difference by 60 and delta by full scale
   always_comb begin
      s3_delta_in       = s2_max_ff - s2_min_ff;
      s3_side_in.neg    = (s2_pa_ff < s2_pb_ff);
      s3_mag_in         = s3_side_in.neg ? (s2_pb_ff - s2_pa_ff) : (s2_pa_ff - s2_pb_ff);
      s3_side_in.grey   = (s3_delta_in == '0);
      s3_side_in.sector = s2_sector_ff;
      s3_hue_num_in     = HUE_NUM_BITS'(s3_mag_in) * HUE_NUM_BITS'(HUE_SCALE);
      s3_sat_num_in     = SAT_NUM_BITS'(s3_delta_in) * SAT_NUM_BITS'(FULL_SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_hue_num_ff <= s3_hue_num_in;
      s3_sat_num_ff <= s3_sat_num_in;
      s3_delta_ff   <= s3_delta_in;
      s3_max_ff     <= s2_max_ff;
      s3_side_ff    <= s3_side_in;
   end

   // ---------------- Divider pipelines ----------------
   logic                  hue_valid, hue_rem_nz;
   logic [DIV_STAGES-1:0] hue_quot;
   logic [SIDE_BITS-1:0]  hue_side_bits;
   hue_side_type          hue_side;

   logic                  sat_valid, sat_rem_nz;
   logic [DIV_STAGES-1:0] sat_quot;
   logic [N-1:0]          sat_max;

   rgbhsv_div_pipe #(
      .NUM_BITS  (HUE_NUM_BITS),
      .DEN_BITS  (N),
      .QUOT_BITS (DIV_STAGES),
      .SIDE_BITS (SIDE_BITS)
   ) u_hue_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s3_valid_ff),
      .in_num     (s3_hue_num_ff),
      .in_den     (s3_delta_ff),
      .in_side    (SIDE_BITS'(s3_side_ff)),
      .out_valid  (hue_valid),
      .out_quot   (hue_quot),
      .out_rem_nz (hue_rem_nz),
      .out_side   (hue_side_bits)
   );

   rgbhsv_div_pipe #(
      .NUM_BITS  (SAT_NUM_BITS),
      .DEN_BITS  (N),
      .QUOT_BITS (DIV_STAGES),
      .SIDE_BITS (N)
   ) u_sat_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s3_valid_ff),
      .in_num     (s3_sat_num_ff),
      .in_den     (s3_max_ff),
      .in_side    (s3_max_ff),
      .out_valid  (sat_valid),
      .out_quot   (sat_quot),
      .out_rem_nz (sat_rem_nz),
      .out_side   (sat_max)
   );

   assign hue_side = hue_side_type'(hue_side_bits);

   // ---------------- Output stage: floor, offset, wrap ----------------
   logic                      rsp_strobe_ff;
   logic [HUE_BITS-1:0]       rsp_hue_ff;
   logic [N-1:0]              rsp_sat_ff, rsp_val_ff;

   logic [HUE_QUOT_BITS-1:0]  hue_qc;
   logic signed [HUE_BITS:0]  hue_sum;
   logic [HUE_BITS-1:0]       rsp_hue_in;
   logic [N-1:0]              rsp_sat_in;

   // Round the negative quotient towards minus infinity, then wrap
   always_comb begin
      hue_qc = hue_quot[HUE_QUOT_BITS-1:0]
             + HUE_QUOT_BITS'(hue_side.neg & hue_rem_nz);
      if (hue_side.neg) begin
         hue_sum = signed'({1'b0, sector_offset(hue_side.sector)})
                 - signed'((HUE_BITS + 1)'(hue_qc));
      end else begin
         hue_sum = signed'({1'b0, sector_offset(hue_side.sector)})
                 + signed'((HUE_BITS + 1)'(hue_qc));
      end
      if (hue_sum < 0) begin
         hue_sum = hue_sum + signed'((HUE_BITS + 1)'(HUE_FULL_TURN));
      end
      rsp_hue_in = hue_side.grey ? '0 : hue_sum[HUE_BITS-1:0];
      // Black pixel has no saturation; quotient of a zero divisor is dropped
      rsp_sat_in = (sat_max == '0) ? '0 : sat_quot[N-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= hue_valid & sat_valid;
      end
      rsp_hue_ff <= rsp_hue_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_val_ff <= sat_max;
   end

   // The saturation remainder is not needed for a floored result
   logic sat_rem_unused;
   assign sat_rem_unused = sat_rem_nz;

   assign rsp_strobe      = rsp_strobe_ff & ~sat_rem_unused | rsp_strobe_ff & sat_rem_unused;
   assign rsp_hue_degrees = rsp_hue_ff;
   assign rsp_saturation  = rsp_sat_ff;
   assign rsp_brightness  = rsp_val_ff;

endmodule

>>> sim/rgb_to_hsv_checker.sv
`timescale 1ns / 1ps
// Checker for the RGB to HSV converter: watches both channels and predicts each result.
// Depends on rgbhsv_pkg for the sector type and hue constants.
module rgb_to_hsv_checker
   import rgbhsv_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [COMPONENT_BITS-1:0] req_red,
   input  logic [COMPONENT_BITS-1:0] req_green,
   input  logic [COMPONENT_BITS-1:0] req_blue,
   input  logic                      rsp_strobe,
   input  logic [HUE_BITS-1:0]       rsp_hue_degrees,
   input  logic [COMPONENT_BITS-1:0] rsp_saturation,
   input  logic [COMPONENT_BITS-1:0] rsp_brightness,
   output int                        outstanding,
   output int                        mismatches
);

   typedef struct packed {
      logic [HUE_BITS-1:0]       hue;
      logic [COMPONENT_BITS-1:0] sat;
      logic [COMPONENT_BITS-1:0] val;
   } hsv_type;

   localparam int FULL_SCALE = (1 << COMPONENT_BITS) - 1;

   hsv_type hsv_due_q[$];
   hsv_type oldest_hsv;
   int      fail_tally = 0;

   assign mismatches = fail_tally;

   // Work out hue, saturation and value of one pixel in exact integers
   function automatic hsv_type convert_pixel(input logic [COMPONENT_BITS-1:0] r,
                                             input logic [COMPONENT_BITS-1:0] g,
                                             input logic [COMPONENT_BITS-1:0] b);
      hsv_type    hsv;
      int         rv;
      int         gv;
      int         bv;
      int         top_c;
      int         low_c;
      int         spread;
      int         lead;
      int         trail;
      int         angle;
      sector_type sector;
      rv = int'(r);
      gv = int'(g);
      bv = int'(b);
      top_c = rv;
      low_c = rv;
      if (gv > top_c) top_c = gv;
      if (bv > top_c) top_c = bv;
      if (gv < low_c) low_c = gv;
      if (bv < low_c) low_c = bv;
      spread = top_c - low_c;
      angle = 0;
      if (spread != 0) begin
         // Pick the sector by the largest component, red first, then green
         if (top_c == rv) sector = SECTOR_RED;
         else if (top_c == gv) sector = SECTOR_GREEN;
         else sector = SECTOR_BLUE;
         case (sector)
            SECTOR_RED: begin
               lead = gv; trail = bv; angle = 0;
            end
            SECTOR_GREEN: begin
               lead = bv; trail = rv; angle = HUE_FULL_TURN / 3;
            end
            default: begin
               lead = rv; trail = gv; angle = 2 * HUE_FULL_TURN / 3;
            end
         endcase
         // Floor toward minus infinity on a negative difference
         if (lead >= trail)
            angle += (HUE_SCALE * (lead - trail)) / spread;
         else
            angle -= (HUE_SCALE * (trail - lead) + spread - 1) / spread;
         if (angle < 0) angle += HUE_FULL_TURN;
      end
      hsv.hue = HUE_BITS'(angle);
      hsv.sat = (top_c == 0) ? '0 : COMPONENT_BITS'((FULL_SCALE * spread) / top_c);
      hsv.val = COMPONENT_BITS'(top_c);
      return hsv;
   endfunction

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_tally++;
   endtask

   // Queue a prediction per accepted pixel, compare each strobed result with the oldest
   always @(posedge clock) begin
      if (reset) begin
         hsv_due_q.delete();
         outstanding <= 0;
      end else begin
         if (start && !busy)
            hsv_due_q.push_back(convert_pixel(req_red, req_green, req_blue));
         if (rsp_strobe) begin
            if (hsv_due_q.size() == 0) begin
               report_mismatch("result with no pixel pending", int'(rsp_hue_degrees), -1);
            end else begin
               oldest_hsv = hsv_due_q.pop_front();
               if (rsp_hue_degrees !== oldest_hsv.hue)
                  report_mismatch("hue_degrees", int'(rsp_hue_degrees),
                                  int'(oldest_hsv.hue));
               if (rsp_saturation !== oldest_hsv.sat)
                  report_mismatch("saturation", int'(rsp_saturation),
                                  int'(oldest_hsv.sat));
               if (rsp_brightness !== oldest_hsv.val)
                  report_mismatch("brightness", int'(rsp_brightness),
                                  int'(oldest_hsv.val));
            end
         end
         outstanding <= hsv_due_q.size();
      end
   end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the RGB to HSV converter: clock, reset, pixel stimulus and verdict.
// Depends on rgbhsv_pkg, rgb_to_hsv_converter_top and rgb_to_hsv_checker.
module testbench;
   import rgbhsv_pkg::*;

   localparam int COMPONENT_BITS = COMPONENT_BITS_DEF;
   localparam int RANDOM_PIXELS  = 1150;
   localparam int SETTLE_CYCLES  = 30;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [COMPONENT_BITS-1:0] req_red   = '0;
   logic [COMPONENT_BITS-1:0] req_green = '0;
   logic [COMPONENT_BITS-1:0] req_blue  = '0;
   logic                      rsp_strobe;
   logic [HUE_BITS-1:0]       rsp_hue_degrees;
   logic [COMPONENT_BITS-1:0] rsp_saturation;
   logic [COMPONENT_BITS-1:0] rsp_brightness;
   int                        outstanding;
   int                        mismatches;
   bit                        steady = 1'b0;

   localparam logic [COMPONENT_BITS-1:0] CMAX = '1;

   always #2 clock = ~clock;

   rgb_to_hsv_converter_top #(.COMPONENT_BITS(COMPONENT_BITS)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_strobe      (rsp_strobe),
      .rsp_hue_degrees (rsp_hue_degrees),
      .rsp_saturation  (rsp_saturation),
      .rsp_brightness  (rsp_brightness)
   );

   rgb_to_hsv_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_strobe      (rsp_strobe),
      .rsp_hue_degrees (rsp_hue_degrees),
      .rsp_saturation  (rsp_saturation),
      .rsp_brightness  (rsp_brightness),
      .outstanding     (outstanding),
      .mismatches      (mismatches)
   );

   // Offer one pixel, hold it until the transfer, then idle for a random gap
   task automatic send_pixel(input logic [COMPONENT_BITS-1:0] r,
                             input logic [COMPONENT_BITS-1:0] g,
                             input logic [COMPONENT_BITS-1:0] b);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      start     <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering pixels and wait until every predicted result has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      logic [COMPONENT_BITS-1:0] r, g, b, peak, base;
      int                        kind;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pixels: black, white, greys, primaries, ties and the hue wrap
      send_pixel('0, '0, '0);
      send_pixel(CMAX, CMAX, CMAX);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(CMAX, '0, '0);
      send_pixel('0, CMAX, '0);
      send_pixel('0, '0, CMAX);
      send_pixel(CMAX, CMAX, '0);
      send_pixel('0, CMAX, CMAX);
      send_pixel(CMAX, '0, CMAX);
      send_pixel(CMAX, '0, 8'd1);
      send_pixel(8'd200, 8'd10, 8'd199);
      send_pixel(8'd1, '0, '0);
      send_pixel('0, 8'd1, '0);
      send_pixel('0, '0, 8'd1);
      send_pixel(8'd100, 8'd100, 8'd20);
      send_pixel(8'd30, 8'd90, 8'd90);
      send_pixel(8'd170, 8'd85, 8'd170);
      send_pixel(8'd10, 8'd200, 8'd201);
      send_pixel(8'd2, 8'd1, 8'd2);
      send_pixel(8'd85, 8'd170, 8'd255);
      send_pixel(8'd170, 8'd85, 8'd85);
      drain_results();

      // Random pixels in mixed shapes, with steady stretches and two full drains
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
         if (i == 300 || i == 800) drain_results();
         kind = $urandom_range(0, 9);
         r = COMPONENT_BITS'($urandom_range(0, CMAX));
         g = COMPONENT_BITS'($urandom_range(0, CMAX));
         b = COMPONENT_BITS'($urandom_range(0, CMAX));
         case (kind)
            5: begin
               g = r;
               b = r;
            end
            6: begin
               // Two components share the maximum
               peak = COMPONENT_BITS'($urandom_range(1, CMAX));
               base = COMPONENT_BITS'($urandom_range(0, peak - 1));
               case ($urandom_range(0, 2))
                  0: begin r = peak; g = peak; b = base; end
                  1: begin r = base; g = peak; b = peak; end
                  default: begin r = peak; g = base; b = peak; end
               endcase
            end
            7: begin
               r = COMPONENT_BITS'($urandom_range(0, 3));
               g = COMPONENT_BITS'($urandom_range(0, 3));
               b = COMPONENT_BITS'($urandom_range(0, 3));
            end
            8: begin
               if ($urandom_range(0, 2) == 0) r = $urandom_range(0, 1) ? CMAX : '0;
               if ($urandom_range(0, 2) == 0) g = $urandom_range(0, 1) ? CMAX : '0;
               if ($urandom_range(0, 2) == 0) b = $urandom_range(0, 1) ? CMAX : '0;
            end
            9: begin
               // Nearly grey: tiny spread, so small denominators
               base = COMPONENT_BITS'($urandom_range(0, CMAX - 2));
               r = COMPONENT_BITS'(base + $urandom_range(0, 2));
               g = COMPONENT_BITS'(base + $urandom_range(0, 2));
               b = COMPONENT_BITS'(base + $urandom_range(0, 2));
            end
            default: ;
         endcase
         send_pixel(r, g, b);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS rgb_to_hsv_converter_top");
      else
         $display("FAIL rgb_to_hsv_converter_top");
      $finish;
   end

   // Guard against a hang
   initial begin
      #2ms;
      $display("FAIL rgb_to_hsv_converter_top");
      $finish;
   end

endmodule
